// ===== hdl/bma_pkg.sv =====
// Shared types and constants for the buddy memory allocator.
// No dependencies; imported by buddy_memory_allocator_top.
package bma_pkg;

   localparam int BMA_MAX_LEVELS = 10;

   localparam int LEN_W  = 22;
   localparam int ADDR_W = 22;
   localparam int STAT_W = 2;

   localparam logic [3:0] MB_RESET  = 4'd7;
   localparam logic [3:0] MB_LOW    = 4'd4;
   localparam logic [3:0] MB_HIGH   = 4'd12;
   localparam logic [3:0] LEV_RESET = 4'd10;
   localparam logic [6:0] HDR_RESET = 7'd16;

   localparam logic [1:0] REG_MIN_BLOCK = 2'd0;
   localparam logic [1:0] REG_LEVELS    = 2'd1;
   localparam logic [1:0] REG_HEADER    = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_OOM      = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

   typedef enum logic [15:0] {
      S_CLEAR = 16'h0001,
      S_INIT  = 16'h0002,
      S_IDLE  = 16'h0004,
      S_ORD   = 16'h0008,
      S_RD    = 16'h0010,
      S_CHK   = 16'h0020,
      S_SPLIT = 16'h0040,
      S_MARK  = 16'h0080,
      S_FSUB  = 16'h0100,
      S_FCHK  = 16'h0200,
      S_FRD   = 16'h0400,
      S_FMK   = 16'h0800,
      S_MRD   = 16'h1000,
      S_MCHK  = 16'h2000,
      S_FSET  = 16'h4000,
      S_OUT   = 16'h8000
   } state_type;

endpackage

// ===== hdl/buddy_memory_allocator_top.sv =====
// Buddy allocator: sequencer, CSR port and the tree/mark/order memories.
// Depends on bma_pkg.
// Allocate tries orders upward to round the length, scans tree nodes through the single
// free-map read port, then splits and marks. Free checks the address and mark, then merges
// while the buddy is free; an allocated buddy stops the merging, and a rejected free skips it.
// One request at a time; the result is held until taken, then the next request is accepted.
// Reset (synchronous) and a write of levels_in_use start a clearing pass over the free map
// and marks, during which no request is taken.
module buddy_memory_allocator_top
   import bma_pkg::*;
#(
   parameter int MAX_LEVELS = BMA_MAX_LEVELS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // request_length[21:0], free_address[43:22], zero pad
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // result_address[21:0], zero pad
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int UNITS  = 1 << MAX_LEVELS;
   localparam int NODES  = (2 << MAX_LEVELS) - 1;
   localparam int NODE_W = MAX_LEVELS + 1;
   localparam int UNIT_W = MAX_LEVELS;
   localparam int ORD_W  = $clog2(MAX_LEVELS + 2);

   function automatic logic [NODE_W-1:0] node_of(input logic [ORD_W-1:0] ord,
                                                input logic [UNIT_W-1:0] blk);
      logic [NODE_W-1:0] base;
      base = (NODE_W'(1) << (MAX_LEVELS - int'(ord))) - NODE_W'(1);
      return base + NODE_W'(blk);
   endfunction

   state_type state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [ORD_W-1:0]  k_ff, k_in, j_ff, j_in;
   logic [UNIT_W-1:0] b_ff, b_in, unit_ff, unit_in;
   logic [LEN_W-1:0]  len_ff, len_in, faddr_ff, faddr_in, off_ff, off_in;
   logic              type_ff, type_in;
   logic [ADDR_W-1:0] res_ff, res_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic [3:0]        mb_ff, lev_ff;
   logic [6:0]        hdr_ff;

   logic              free_mem [NODES];
   logic              mark_mem [UNITS];
   logic [ORD_W-1:0]  order_mem [UNITS];
   logic              fm_rd_ff, mk_rd_ff;
   logic [ORD_W-1:0]  ord_rd_ff;

   logic              fm_we, fm_wd, mk_we, mk_wd, ord_we;
   logic [NODE_W-1:0] fm_wa, fm_ra;
   logic [UNIT_W-1:0] mk_wa;

   logic              cfg_wr;
   logic [3:0]        wval;
   logic [ORD_W-1:0]  lev_o;
   logic [LEN_W:0]    need;
   logic [5:0]        sh;
   logic              fits;
   logic [UNIT_W:0]   last_b;
   logic [LEN_W-1:0]  ushift;
   logic [28:0]       addr_full;
   logic [ORD_W-1:0]  jm1;

   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wval       = csr_pwdata[3:0];
   assign csr_pready = 1'b1;
   assign lev_o      = ORD_W'(lev_ff);

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MIN_BLOCK: csr_prdata = {28'd0, mb_ff};
         REG_LEVELS:    csr_prdata = {28'd0, lev_ff};
         REG_HEADER:    csr_prdata = {25'd0, hdr_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mb_ff  <= MB_RESET;
         lev_ff <= (int'(LEV_RESET) > MAX_LEVELS) ? 4'(MAX_LEVELS) : LEV_RESET;
         hdr_ff <= HDR_RESET;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_MIN_BLOCK: mb_ff  <= (wval < MB_LOW) ? MB_LOW :
                                     (wval > MB_HIGH) ? MB_HIGH : wval;
            REG_LEVELS:    lev_ff <= (int'(wval) > MAX_LEVELS) ? 4'(MAX_LEVELS) : wval;
            REG_HEADER:    hdr_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   // Memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (fm_we) begin
         free_mem[fm_wa] <= fm_wd;
      end
      fm_rd_ff <= free_mem[fm_ra];
      if (mk_we) begin
         mark_mem[mk_wa] <= mk_wd;
      end
      if (ord_we) begin
         order_mem[mk_wa] <= k_ff;
      end
      mk_rd_ff  <= mark_mem[unit_ff];
      ord_rd_ff <= order_mem[unit_ff];
   end

   always_comb begin
      need      = (LEN_W+1)'(len_ff) + (LEN_W+1)'(hdr_ff);
      sh        = 6'(mb_ff) + 6'(k_ff);
      fits      = (sh >= 6'(LEN_W + 1)) || (((LEN_W+1)'(1) << sh) >= need);
      last_b    = ((UNIT_W+1)'(1) << (lev_o - j_ff)) - (UNIT_W+1)'(1);
      ushift    = off_ff >> mb_ff;
      addr_full = (29'(unit_ff) << mb_ff) + 29'(hdr_ff);
      jm1       = j_ff - ORD_W'(1);
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      b_in     = b_ff;
      unit_in  = unit_ff;
      len_in   = len_ff;
      faddr_in = faddr_ff;
      off_in   = off_ff;
      type_in  = type_ff;
      res_in   = res_ff;
      stat_in  = stat_ff;
      fm_we    = 1'b0;
      fm_wd    = 1'b0;
      fm_wa    = clr_ff;
      fm_ra    = node_of(j_ff, b_ff);
      mk_we    = 1'b0;
      mk_wd    = 1'b0;
      mk_wa    = unit_ff;
      ord_we   = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            fm_we = 1'b1;
            if (!clr_ff[NODE_W-1]) begin
               mk_we = 1'b1;
               mk_wa = clr_ff[UNIT_W-1:0];
            end
            clr_in = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(NODES - 1)) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            fm_we    = 1'b1;
            fm_wd    = 1'b1;
            fm_wa    = node_of(lev_o, '0);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               len_in   = req_tdata[21:0];
               faddr_in = req_tdata[43:22];
               type_in  = req_tuser;
               k_in     = '0;
               state_in = (req_tuser == REQ_FREE) ? S_FSUB : S_ORD;
            end
         end
         S_ORD: begin
            if (k_ff > lev_o) begin
               res_in   = '0;
               stat_in  = ST_OOM;
               state_in = S_OUT;
            end else if (fits) begin
               j_in     = k_ff;
               b_in     = '0;
               state_in = S_RD;
            end else begin
               k_in = k_ff + ORD_W'(1);
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (fm_rd_ff) begin
               fm_we    = 1'b1;
               fm_wa    = node_of(j_ff, b_ff);
               unit_in  = b_ff << j_ff;
               state_in = S_SPLIT;
            end else if ((UNIT_W+1)'(b_ff) == last_b) begin
               if (j_ff >= lev_o) begin
                  res_in   = '0;
                  stat_in  = ST_OOM;
                  state_in = S_OUT;
               end else begin
                  j_in     = j_ff + ORD_W'(1);
                  b_in     = '0;
                  state_in = S_RD;
               end
            end else begin
               b_in     = b_ff + UNIT_W'(1);
               state_in = S_RD;
            end
         end
         S_SPLIT: begin
            // Each split frees the upper half one order down.
            if (j_ff > k_ff) begin
               fm_we = 1'b1;
               fm_wd = 1'b1;
               fm_wa = node_of(jm1, (unit_ff >> jm1) + UNIT_W'(1));
               j_in  = jm1;
            end else begin
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            mk_we    = 1'b1;
            mk_wd    = 1'b1;
            ord_we   = 1'b1;
            res_in   = addr_full[ADDR_W-1:0];
            stat_in  = ST_OK;
            state_in = S_OUT;
         end
         S_FSUB: begin
            if (faddr_ff < LEN_W'(hdr_ff)) begin
               res_in   = '0;
               stat_in  = ST_BAD_FREE;
               state_in = S_OUT;
            end else begin
               off_in   = faddr_ff - LEN_W'(hdr_ff);
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (((off_ff & ((LEN_W'(1) << mb_ff) - LEN_W'(1))) != '0) ||
                ((ushift >> lev_ff) != '0)) begin
               res_in   = '0;
               stat_in  = ST_BAD_FREE;
               state_in = S_OUT;
            end else begin
               unit_in  = ushift[UNIT_W-1:0];
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            state_in = S_FMK;
         end
         S_FMK: begin
            if (!mk_rd_ff) begin
               res_in   = '0;
               stat_in  = ST_BAD_FREE;
               state_in = S_OUT;
            end else begin
               mk_we    = 1'b1;
               k_in     = (ord_rd_ff > lev_o) ? lev_o : ord_rd_ff;
               state_in = S_MRD;
            end
         end
         S_MRD: begin
            fm_ra    = node_of(k_ff, (unit_ff >> k_ff) ^ UNIT_W'(1));
            state_in = (k_ff < lev_o) ? S_MCHK : S_FSET;
         end
         S_MCHK: begin
            if (fm_rd_ff) begin
               fm_we    = 1'b1;
               fm_wa    = node_of(k_ff, (unit_ff >> k_ff) ^ UNIT_W'(1));
               unit_in  = unit_ff & ~(UNIT_W'(1) << k_ff);
               k_in     = k_ff + ORD_W'(1);
               state_in = S_MRD;
            end else begin
               state_in = S_FSET;
            end
         end
         S_FSET: begin
            fm_we    = 1'b1;
            fm_wd    = 1'b1;
            fm_wa    = node_of(k_ff, unit_ff >> k_ff);
            res_in   = '0;
            stat_in  = ST_OK;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase

      // A new pool depth restarts the clearing pass.
      if (cfg_wr && csr_paddr[3:2] == REG_LEVELS) begin
         state_in = S_CLEAR;
         clr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      k_ff     <= k_in;
      j_ff     <= j_in;
      b_ff     <= b_in;
      unit_ff  <= unit_in;
      len_ff   <= len_in;
      faddr_ff <= faddr_in;
      off_ff   <= off_in;
      type_ff  <= type_in;
      res_ff   <= res_in;
      stat_ff  <= stat_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {2'b00, res_ff};
   assign rsp_tuser  = stat_ff;

   a_stat_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (stat_ff == ST_OK || stat_ff == ST_OOM || stat_ff == ST_BAD_FREE))
      else $error("invalid status code");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && stat_ff != ST_OK) |-> (res_ff == '0))
      else $error("failed request carries an address");
   a_free_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && type_ff == REQ_FREE) |-> (res_ff == '0 && stat_ff != ST_OOM))
      else $error("free response malformed");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while response pending");

endmodule
